// ----- rtl/ipu_pkg.sv -----
package ipu_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned DIGIT_MAX = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_POW = 2'd3
    } t_op;

    typedef struct packed {
        logic start;
    } t_mul_ctrl;

    typedef struct packed {
        logic done;
        logic busy;
    } t_mul_stat;

endpackage

// ----- rtl/ipu_digit_mul.sv -----
module ipu_digit_mul #(
    parameter int unsigned WORD_WIDTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ipu_pkg::t_mul_ctrl      i_ctrl,
    input  logic [WORD_WIDTH-1:0]   i_a,
    input  logic [WORD_WIDTH-1:0]   i_b,
    output ipu_pkg::t_mul_stat      o_stat,
    output logic [WORD_WIDTH-1:0]   o_product
);

    localparam int unsigned DIGIT_W = (WORD_WIDTH < ipu_pkg::DIGIT_MAX) ?
                                      WORD_WIDTH : ipu_pkg::DIGIT_MAX;
    localparam int unsigned STEPS   = (WORD_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int unsigned CNT_W   = $clog2(STEPS + 1);

    logic [WORD_WIDTH-1:0]         r_a;
    logic [WORD_WIDTH-1:0]         r_b;
    logic [WORD_WIDTH-1:0]         r_acc;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [WORD_WIDTH+DIGIT_W-1:0] w_part;

    // one digit of the multiplier per cycle, product kept modulo the word
    assign w_part = {{DIGIT_W{1'b0}}, r_a} * {{WORD_WIDTH{1'b0}}, r_b[DIGIT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start && !r_busy) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= CNT_W'(STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + w_part[WORD_WIDTH-1:0];
                r_a   <= r_a << DIGIT_W;
                r_b   <= r_b >> DIGIT_W;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.busy = r_busy;
    assign o_product   = r_acc;

endmodule

// ----- rtl/integer_arith_power_unit.sv -----
// add and subtract are computed when the item is accepted; multiply uses the multiplier
// power: square-and-multiply, a multiply per set exponent bit and a square per bit
// below the top set bit; all products come from one shared 16-bit-digit multiplier
// (4 steps a product at WORD_WIDTH 64)
// one item in flight; a new item is taken while the last result waits at the output
// reset: synchronous active-low i_rst_n clears the control and the output valid
module integer_arith_power_unit #(
    parameter int unsigned WORD_WIDTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // operand_a, operand_b
    input  logic [1:0]   s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata   // result_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_POW_CHK,
        S_POW_ACC,
        S_POW_SQR,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [WORD_WIDTH-1:0]        r_res;
    logic [WORD_WIDTH-1:0]        r_base;
    logic [WORD_WIDTH-1:0]        r_exp;
    logic [WORD_WIDTH-1:0]        r_mul_a;
    logic [WORD_WIDTH-1:0]        r_mul_b;
    logic                         r_mul_start;
    logic                         r_m_valid;
    logic [ipu_pkg::DATA_W-1:0]   r_m_data;

    ipu_pkg::t_mul_ctrl           w_mul_ctrl;
    ipu_pkg::t_mul_stat           w_mul_stat;
    logic [WORD_WIDTH-1:0]        w_product;
    logic [WORD_WIDTH-1:0]        w_a;
    logic [WORD_WIDTH-1:0]        w_b;
    ipu_pkg::t_op                 w_op;
    logic                         w_s_acc;
    logic                         w_out_free;
    logic signed [ipu_pkg::DATA_W-1:0] w_ext;

    assign w_a        = s_axis_tdata[WORD_WIDTH-1:0];
    assign w_b        = s_axis_tdata[ipu_pkg::DATA_W+WORD_WIDTH-1:ipu_pkg::DATA_W];
    assign w_op       = ipu_pkg::t_op'(s_axis_tuser);
    assign w_s_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_ext      = ipu_pkg::DATA_W'($signed(r_res));

    assign w_mul_ctrl.start = r_mul_start;

    ipu_digit_mul #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_mul_ctrl),
        .i_a       (r_mul_a),
        .i_b       (r_mul_b),
        .o_stat    (w_mul_stat),
        .o_product (w_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        unique case (w_op)
                            ipu_pkg::OP_ADD: begin
                                r_res   <= w_a + w_b;
                                r_state <= S_DONE;
                            end
                            ipu_pkg::OP_SUB: begin
                                r_res   <= w_a - w_b;
                                r_state <= S_DONE;
                            end
                            ipu_pkg::OP_MUL: begin
                                r_mul_a     <= w_a;
                                r_mul_b     <= w_b;
                                r_mul_start <= 1'b1;
                                r_state     <= S_MUL;
                            end
                            ipu_pkg::OP_POW: begin
                                r_base  <= w_a;
                                r_exp   <= w_b;
                                r_res   <= WORD_WIDTH'(1);
                                r_state <= S_POW_CHK;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (w_mul_stat.done) begin
                        r_res   <= w_product;
                        r_state <= S_DONE;
                    end
                end
                S_POW_CHK: begin
                    priority if (r_exp == '0) begin
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_mul_a     <= r_res;
                        r_mul_b     <= r_base;
                        r_mul_start <= 1'b1;
                        r_state     <= S_POW_ACC;
                    end else begin
                        r_mul_a     <= r_base;
                        r_mul_b     <= r_base;
                        r_mul_start <= 1'b1;
                        r_state     <= S_POW_SQR;
                    end
                end
                S_POW_ACC: begin
                    if (w_mul_stat.done) begin
                        r_res <= w_product;
                        // no square needed after the top set bit
                        if (r_exp[WORD_WIDTH-1:1] == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_mul_a     <= r_base;
                            r_mul_b     <= r_base;
                            r_mul_start <= 1'b1;
                            r_state     <= S_POW_SQR;
                        end
                    end
                end
                S_POW_SQR: begin
                    if (w_mul_stat.done) begin
                        r_base  <= w_product;
                        r_exp   <= r_exp >> 1;
                        r_state <= S_POW_CHK;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_data  <= w_ext;
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !s_axis_tready)
        else $error("item accepted while another is in flight");

    a_mul_done_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_stat.done |-> (r_state == S_MUL || r_state == S_POW_ACC ||
                             r_state == S_POW_SQR))
        else $error("multiplier finished with no operation waiting");

    a_start_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_start |-> !w_mul_stat.busy)
        else $error("multiplier started while busy");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (m_axis_tvalid && s_axis_tready))
        else $error("finished result not presented");

endmodule

// ----- sim/tb_integer_arith_power_unit.sv -----
module tb_integer_arith_power_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WORD_WIDTH  = 64;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT = 6000;
    localparam int unsigned DRAIN_WAIT  = 900;
    localparam int unsigned PHASE_ITEMS = 300;

    typedef struct {
        ipu_pkg::t_op op;
        logic [63:0]  a;
        logic [63:0]  b;
    } t_item;

    typedef struct {
        t_item       src;
        logic [63:0] value;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;  // operand_a, operand_b
    logic [1:0]   s_axis_tuser = '0;  // operation
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;       // result_value

    t_item       pending_items[$];
    t_result     pending_results[$];
    t_item       next_item;
    t_result     got;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          in_fire = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatch_cnt = 0;

    integer_arith_power_unit #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // wraps to the word width and sign-extends back to 64 bits
    function automatic logic [63:0] arith_result(ipu_pkg::t_op op, logic [63:0] a,
                                                 logic [63:0] b);
        logic [63:0] mask;
        logic [63:0] sign;
        logic [63:0] acc;
        logic [63:0] base;
        logic [63:0] r;
        mask = (WORD_WIDTH == 64) ? '1 : ((64'd1 << WORD_WIDTH) - 64'd1);
        sign = 64'd1 << (WORD_WIDTH - 1);
        a &= mask;
        b &= mask;
        case (op)
            ipu_pkg::OP_ADD: r = a + b;
            ipu_pkg::OP_SUB: r = a - b;
            ipu_pkg::OP_MUL: r = a * b;
            default: begin
                acc = 64'd1;
                base = a;
                for (int i = 0; i < WORD_WIDTH; i++) begin
                    if (b[i]) begin
                        acc = (acc * base) & mask;
                    end
                    base = (base * base) & mask;
                end
                r = acc;
            end
        endcase
        r &= mask;
        return (r ^ sign) - sign;
    endfunction

    task automatic push_item(ipu_pkg::t_op op, logic [63:0] a, logic [63:0] b);
        t_item it;
        it.op = op;
        it.a = a;
        it.b = b;
        pending_items.push_back(it);
    endtask

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(9))
            0: w = 64'h7fff_ffff_ffff_ffff;
            1: w = 64'h8000_0000_0000_0000;
            2: w = '1;
            3: w = 64'($urandom_range(3));
            default: ;
        endcase
        return w;
    endfunction

    task automatic push_random(int unsigned n);
        ipu_pkg::t_op op;
        logic [63:0]  b;
        for (int unsigned k = 0; k < n; k++) begin
            op = ipu_pkg::t_op'($urandom_range(3));
            b = rand_word();
            // most powers use short exponents, a few scan all bits
            if (op == ipu_pkg::OP_POW && $urandom_range(9) != 0) begin
                b = {$urandom, $urandom} & ((64'd1 << $urandom_range(12)) - 64'd1);
            end
            push_item(op, rand_word(), b);
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_items.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {next_item.b, next_item.a};
                s_axis_tuser <= next_item.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver readiness, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            got.src.op = ipu_pkg::t_op'(s_axis_tuser);
            got.src.a = s_axis_tdata[63:0];
            got.src.b = s_axis_tdata[127:64];
            got.value = arith_result(got.src.op, got.src.a, got.src.b);
            pending_results.push_back(got);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("ERROR: unexpected result %h", m_axis_tdata);
                end
            end else begin
                got = pending_results.pop_front();
                if (m_axis_tdata !== got.value) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("ERROR: op %s a %h b %h expected %h got %h", got.src.op.name(),
                                 got.src.a, got.src.b, got.value, m_axis_tdata);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // overflow, wrap and power corner cases
        push_item(ipu_pkg::OP_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1);
        push_item(ipu_pkg::OP_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        push_item(ipu_pkg::OP_ADD, '1, '1);
        push_item(ipu_pkg::OP_SUB, 64'h8000_0000_0000_0000, 64'd1);
        push_item(ipu_pkg::OP_SUB, 64'd0, 64'h7fff_ffff_ffff_ffff);
        push_item(ipu_pkg::OP_SUB, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
        push_item(ipu_pkg::OP_MUL, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
        push_item(ipu_pkg::OP_MUL, 64'h8000_0000_0000_0000, '1);
        push_item(ipu_pkg::OP_MUL, 64'd0, 64'h1234_5678_9abc_def0);
        push_item(ipu_pkg::OP_MUL, '1, '1);
        push_item(ipu_pkg::OP_POW, 64'd0, 64'd0);
        push_item(ipu_pkg::OP_POW, 64'h7fff_ffff_ffff_ffff, 64'd0);
        push_item(ipu_pkg::OP_POW, 64'd2, 64'd63);
        push_item(ipu_pkg::OP_POW, 64'd2, 64'd64);
        push_item(ipu_pkg::OP_POW, '1, '1);
        push_item(ipu_pkg::OP_POW, 64'd3, '1);
        push_item(ipu_pkg::OP_POW, 64'h8000_0000_0000_0000, 64'd1);
        push_item(ipu_pkg::OP_POW, 64'd0, 64'd5);
        push_item(ipu_pkg::OP_POW, -64'sd2, 64'd3);
        push_item(ipu_pkg::OP_POW, 64'd1, 64'h7fff_ffff_ffff_ffff);
        push_item(ipu_pkg::OP_POW, 64'd3, 64'h8000_0000_0000_0000);
        push_item(ipu_pkg::OP_POW, 64'hdead_beef_cafe_f00d, 64'd40);
        wait_drained();

        // no idling, with a long output hold-off at the start
        hold_request = 1'b1;
        push_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 58;
        recv_stall_pct = 0;
        push_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 58;
        push_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 18;
        recv_stall_pct = 18;
        push_random(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
